// ----- rtl/core/gram_schmidt_orthonormalizer_unit_assert.svh -----
// Assertion macros for the Gram-Schmidt orthonormalizer.
`ifndef GRAM_SCHMIDT_ORTHONORMALIZER_UNIT_ASSERT_SVH
`define GRAM_SCHMIDT_ORTHONORMALIZER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define GSO_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define GSO_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define GSO_ASSERT(label, cond)
`define GSO_ASSERT_IMP(label, ante, cons)
`endif
`endif

// ----- rtl/core/gso_pkg.sv -----
// Package with constants and saturation helpers for the orthonormalizer.
`timescale 1ns / 1ps
package gso_pkg;
    localparam int MAX_VECTORS_DEF = 8;
    localparam int DIM_DEF         = 4;
    localparam int NUM_COMPS       = 4;
    localparam int ONE_Q14         = 16384;
    localparam int IDX_W           = 3;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [48:0] x);
        if (x > 49'sd2147483647)
            return 32'h7FFFFFFF;
        if (x < -49'sd2147483648)
            return 32'h80000000;
        return x[31:0];
    endfunction
endpackage

// ----- rtl/core/gram_schmidt_orthonormalizer_unit.sv -----
// Gram-Schmidt orthonormalizer: vector store in one RAM with a shared sequencer.
//
// Input requests carry one Q8.8 vector of four components in s_tdata; s_tlast
// marks the last vector of a set. Each vector is written to the vector RAM one
// component per cycle. Vectors beyond MAX_VECTORS are discarded and every
// result of that set reports dropped.
// After the last vector the block runs modified Gram-Schmidt over the set and
// emits one Q1.14 result request per vector on the master side, in load order,
// with m_tlast on the final one. All work runs through one RAM read port, one
// 32x32 multiplier, one restoring divider (one quotient bit per cycle) and one
// bit-pair square root unit. No new vector is taken while a set is in work or a
// result waits. A stalled receiver holds the result register; the sequencer
// waits for it. Reset clears the fill count and the overflow flag; the vector
// RAM holds no reset value and only entries of the current set are ever used.
`timescale 1ns / 1ps
`include "gram_schmidt_orthonormalizer_unit_assert.svh"
module gram_schmidt_orthonormalizer_unit
    import gso_pkg::*;
#(
    parameter int MAX_VECTORS = MAX_VECTORS_DEF,
    parameter int DIM         = DIM_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // comp0, comp1, comp2, comp3
    input  logic        s_tlast,   // last_vector
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // out0, out1, out2, out3, vector_index, zero fill
    output logic [1:0]  m_tuser,   // degenerate, dropped
    output logic        m_tlast    // last
);
    localparam int DEPTH = MAX_VECTORS * DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_VECTORS + 1);
    localparam int KMAX  = (DIM > NUM_COMPS) ? DIM : NUM_COMPS;
    localparam int KW    = $clog2(KMAX + 1);

    typedef enum logic [28:0] {
        S_IDLE  = 29'b1 << 0,  S_LOAD  = 29'b1 << 1,  S_PAIR  = 29'b1 << 2,
        S_D_RJ  = 29'b1 << 3,  S_D_RI  = 29'b1 << 4,  S_D_MB  = 29'b1 << 5,
        S_D_P1  = 29'b1 << 6,  S_D_P2  = 29'b1 << 7,  S_D_P3  = 29'b1 << 8,
        S_DIVS  = 29'b1 << 9,  S_DIV   = 29'b1 << 10, S_FSET  = 29'b1 << 11,
        S_U_RJ  = 29'b1 << 12, S_U_RI  = 29'b1 << 13, S_U_MB  = 29'b1 << 14,
        S_U_W   = 29'b1 << 15, S_NEXTJ = 29'b1 << 16, S_N_RD  = 29'b1 << 17,
        S_N_RA  = 29'b1 << 18, S_N_P   = 29'b1 << 19, S_N_ACC = 29'b1 << 20,
        S_SQS   = 29'b1 << 21, S_SQ    = 29'b1 << 22, S_O_CHK = 29'b1 << 23,
        S_O_RD  = 29'b1 << 24, S_O_RA  = 29'b1 << 25, S_OSET  = 29'b1 << 26,
        S_EMIT  = 29'b1 << 27, S_OUT   = 29'b1 << 28
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next, i_reg, i_next, j_reg, j_next;
    logic [KW-1:0] k_reg, k_next;
    logic ovf_reg, ovf_next, last_reg, last_next, div_out_reg, div_out_next;
    logic neg_reg, neg_next, valid_reg, valid_next;
    logic signed [15:0] comp_reg [NUM_COMPS];
    logic signed [15:0] comp_next [NUM_COMPS];
    logic signed [15:0] outc_reg [NUM_COMPS];
    logic signed [15:0] outc_next [NUM_COMPS];
    logic signed [31:0] a_reg, a_next, b_reg, b_next, f_reg, f_next;
    logic signed [31:0] mul_x, mul_y;
    logic signed [63:0] prod_reg, num_reg, num_next, den_reg, den_next;
    logic [63:0] div_r_reg, div_r_next, div_d_reg, div_d_next;
    logic [30:0] div_s_reg, div_s_next, div_q_reg, div_q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] sq_n_reg, sq_n_next, sq_res_reg, sq_res_next, sq_bit_reg, sq_bit_next;
    logic [31:0] norm_reg, norm_next;
    logic [71:0] tdata_reg, tdata_next;
    logic [1:0]  tuser_reg, tuser_next;
    logic        tlast_reg, tlast_next;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rdata_reg, mem_wdata;
    logic [AW-1:0] mem_raddr, mem_waddr, addr_i, addr_j, addr_load;
    logic mem_we;

    logic [63:0] num_mag, pmag, sq_sum;
    logic [64:0] div_r2;
    logic [31:0] c_mag;
    logic signed [48:0] upd_diff;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    assign addr_i    = AW'(i_reg * DIM + k_reg);
    assign addr_j    = AW'(j_reg * DIM + k_reg);
    assign addr_load = AW'(count_reg * DIM + k_reg);

    always_comb
    begin
        mem_raddr = addr_i;
        if (state_reg == S_D_RJ || state_reg == S_U_RJ)
            mem_raddr = addr_j;
        mem_we    = 1'b0;
        mem_waddr = addr_i;
        mem_wdata = sat32(upd_diff);
        if (state_reg == S_LOAD)
        begin
            mem_we    = 1'b1;
            mem_waddr = addr_load;
            mem_wdata = (k_reg < KW'(NUM_COMPS)) ?
                        {{8{comp_reg[k_reg[1:0]][15]}}, comp_reg[k_reg[1:0]], 8'd0} : 32'sd0;
        end
        else if (state_reg == S_U_W)
            mem_we = 1'b1;
    end

    always_comb
    begin
        mul_x = a_reg;
        mul_y = b_reg;
        if (state_reg == S_D_P2 || state_reg == S_N_P)
            mul_y = a_reg;
        else if (state_reg == S_U_MB)
        begin
            mul_x = f_reg;
            mul_y = a_reg;
        end
    end

    always_ff @(posedge clk)
        prod_reg <= mul_x * mul_y;

    assign num_mag  = num_reg[63] ? 64'(-num_reg) : 64'(num_reg);
    assign pmag     = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
    // The scaled projection keeps the sign of the product.
    assign upd_diff = prod_reg[63] ? ({{17{b_reg[31]}}, b_reg} + {1'b0, pmag[63:16]})
                                   : ({{17{b_reg[31]}}, b_reg} - {1'b0, pmag[63:16]});
    assign div_r2   = {div_r_reg, div_s_reg[30]};
    assign sq_sum   = sq_res_reg + sq_bit_reg;
    assign c_mag    = rdata_reg[31] ? 32'(-rdata_reg) : 32'(rdata_reg);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        ovf_next     = ovf_reg;
        last_next    = last_reg;
        div_out_next = div_out_reg;
        neg_next     = neg_reg;
        valid_next   = valid_reg;
        comp_next    = comp_reg;
        outc_next    = outc_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        f_next       = f_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        div_r_next   = div_r_reg;
        div_d_next   = div_d_reg;
        div_s_next   = div_s_reg;
        div_q_next   = div_q_reg;
        cnt_next     = cnt_reg;
        sq_n_next    = sq_n_reg;
        sq_res_next  = sq_res_reg;
        sq_bit_next  = sq_bit_reg;
        norm_next    = norm_reg;
        tdata_next   = tdata_reg;
        tuser_next   = tuser_reg;
        tlast_next   = tlast_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    for (int c = 0; c < NUM_COMPS; c++)
                        comp_next[c] = s_tdata[16*c +: 16];
                    last_next = s_tlast;
                    k_next    = '0;
                    i_next    = CW'(1);
                    j_next    = '0;
                    if (count_reg < CW'(MAX_VECTORS))
                        state_next = S_LOAD;
                    else
                    begin
                        ovf_next = 1'b1;
                        if (s_tlast)
                            state_next = S_PAIR;
                    end
                end
            end
            S_LOAD:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg == KW'(DIM - 1))
                begin
                    count_next = count_reg + 1'b1;
                    state_next = last_reg ? S_PAIR : S_IDLE;
                end
            end
            S_PAIR:
            begin
                k_next   = '0;
                num_next = '0;
                den_next = '0;
                if (i_reg >= count_reg)
                begin
                    i_next     = '0;
                    state_next = S_N_RD;
                end
                else
                    state_next = S_D_RJ;
            end
            S_D_RJ: state_next = S_D_RI;
            S_D_RI:
            begin
                a_next     = rdata_reg;
                state_next = S_D_MB;
            end
            S_D_MB:
            begin
                b_next     = rdata_reg;
                state_next = S_D_P1;
            end
            S_D_P1: state_next = S_D_P2;
            S_D_P2:
            begin
                num_next   = sat_add64(num_reg, prod_reg);
                state_next = S_D_P3;
            end
            S_D_P3:
            begin
                den_next = sat_add64(den_reg, prod_reg);
                k_next   = k_reg + 1'b1;
                state_next = (k_reg == KW'(DIM - 1)) ? S_DIVS : S_D_RJ;
            end
            S_DIVS:
            begin
                neg_next     = num_reg[63];
                div_out_next = 1'b0;
                k_next       = '0;
                if (den_reg == 64'sd0)
                    state_next = S_NEXTJ;
                else if ({14'd0, num_mag} >= {den_reg[62:0], 15'd0})
                begin
                    // Quotient of 2^15 or more saturates the factor.
                    f_next     = num_reg[63] ? -32'sh7FFFFFFF : 32'sh7FFFFFFF;
                    state_next = S_U_RJ;
                end
                else
                begin
                    div_r_next = num_mag >> 15;
                    div_s_next = {num_mag[14:0], 16'd0};
                    div_q_next = '0;
                    div_d_next = den_reg;
                    cnt_next   = 6'd31;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                div_s_next = div_s_reg << 1;
                if (div_r2 >= {1'b0, div_d_reg})
                begin
                    div_r_next = 64'(div_r2 - {1'b0, div_d_reg});
                    div_q_next = {div_q_reg[29:0], 1'b1};
                end
                else
                begin
                    div_r_next = div_r2[63:0];
                    div_q_next = {div_q_reg[29:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 6'd1)
                    state_next = div_out_reg ? S_OSET : S_FSET;
            end
            S_FSET:
            begin
                f_next     = neg_reg ? -$signed({1'b0, div_q_reg}) : $signed({1'b0, div_q_reg});
                state_next = S_U_RJ;
            end
            S_U_RJ: state_next = S_U_RI;
            S_U_RI:
            begin
                a_next     = rdata_reg;
                state_next = S_U_MB;
            end
            S_U_MB:
            begin
                b_next     = rdata_reg;
                state_next = S_U_W;
            end
            S_U_W:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg == KW'(DIM - 1))
                    state_next = S_NEXTJ;
                else
                    state_next = S_U_RJ;
            end
            S_NEXTJ:
            begin
                if (CW'(j_reg + 1'b1) == i_reg)
                begin
                    i_next = i_reg + 1'b1;
                    j_next = '0;
                end
                else
                    j_next = j_reg + 1'b1;
                state_next = S_PAIR;
            end
            S_N_RD: state_next = S_N_RA;
            S_N_RA:
            begin
                a_next     = rdata_reg;
                state_next = S_N_P;
            end
            S_N_P: state_next = S_N_ACC;
            S_N_ACC:
            begin
                den_next = sat_add64(den_reg, prod_reg);
                k_next   = k_reg + 1'b1;
                state_next = (k_reg == KW'(DIM - 1)) ? S_SQS : S_N_RD;
            end
            S_SQS:
            begin
                k_next = '0;
                if (den_reg == 64'sd0)
                begin
                    norm_next = '0;
                    for (int c = 0; c < NUM_COMPS; c++)
                        outc_next[c] = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    sq_n_next   = den_reg;
                    sq_res_next = '0;
                    sq_bit_next = 64'd1 << 62;
                    cnt_next    = 6'd32;
                    state_next  = S_SQ;
                end
            end
            S_SQ:
            begin
                if (sq_n_reg >= sq_sum)
                begin
                    sq_n_next   = sq_n_reg - sq_sum;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_next = sq_res_reg >> 1;
                sq_bit_next = sq_bit_reg >> 2;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == 6'd1)
                begin
                    norm_next  = sq_res_next[31:0];
                    state_next = S_O_CHK;
                end
            end
            S_O_CHK:
            begin
                if (k_reg == KW'(NUM_COMPS))
                    state_next = S_EMIT;
                else if (k_reg >= KW'(DIM))
                begin
                    outc_next[k_reg[1:0]] = '0;
                    k_next = k_reg + 1'b1;
                end
                else
                    state_next = S_O_RD;
            end
            S_O_RD: state_next = S_O_RA;
            S_O_RA:
            begin
                neg_next     = rdata_reg[31];
                div_out_next = 1'b1;
                if (c_mag >= norm_reg)
                begin
                    outc_next[k_reg[1:0]] = rdata_reg[31] ? -16'(ONE_Q14) : 16'(ONE_Q14);
                    k_next     = k_reg + 1'b1;
                    state_next = S_O_CHK;
                end
                else
                begin
                    div_r_next = {32'd0, c_mag};
                    div_s_next = '0;
                    div_q_next = '0;
                    div_d_next = {32'd0, norm_reg};
                    cnt_next   = 6'd14;
                    state_next = S_DIV;
                end
            end
            S_OSET:
            begin
                outc_next[k_reg[1:0]] = neg_reg ? -$signed({1'b0, div_q_reg[14:0]})
                                                :  $signed({1'b0, div_q_reg[14:0]});
                k_next     = k_reg + 1'b1;
                state_next = S_O_CHK;
            end
            S_EMIT:
            begin
                tdata_next = {5'd0, IDX_W'(i_reg), outc_reg[3], outc_reg[2],
                              outc_reg[1], outc_reg[0]};
                tuser_next = {ovf_reg, norm_reg == 32'd0};
                tlast_next = (CW'(i_reg + 1'b1) == count_reg);
                valid_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    valid_next = 1'b0;
                    k_next     = '0;
                    den_next   = '0;
                    if (CW'(i_reg + 1'b1) == count_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_N_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        k_reg       <= k_next;
        last_reg    <= last_next;
        div_out_reg <= div_out_next;
        neg_reg     <= neg_next;
        comp_reg    <= comp_next;
        outc_reg    <= outc_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        f_reg       <= f_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        div_r_reg   <= div_r_next;
        div_d_reg   <= div_d_next;
        div_s_reg   <= div_s_next;
        div_q_reg   <= div_q_next;
        cnt_reg     <= cnt_next;
        sq_n_reg    <= sq_n_next;
        sq_res_reg  <= sq_res_next;
        sq_bit_reg  <= sq_bit_next;
        norm_reg    <= norm_next;
        tdata_reg   <= tdata_next;
        tuser_reg   <= tuser_next;
        tlast_reg   <= tlast_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

    `GSO_ASSERT(a_in_out_exclusive, !(s_tready && m_tvalid))
    `GSO_ASSERT(a_count_bound, count_reg <= CW'(MAX_VECTORS))
    `GSO_ASSERT_IMP(a_valid_in_out_state, m_tvalid, state_reg == S_OUT)
    `GSO_ASSERT_IMP(a_last_clears_set, m_tvalid && m_tready && m_tlast,
                    ##1 (count_reg == '0 && !ovf_reg))
endmodule

// ----- verif/gram_schmidt_orthonormalizer_unit_tb.sv -----
// Testbench for the Gram-Schmidt orthonormalizer with a fixed-point predictor and result checker.
`timescale 1ns / 1ps
module gram_schmidt_orthonormalizer_unit_tb
    import gso_pkg::*;
;
    localparam int NVEC = MAX_VECTORS_DEF;
    localparam int NDIM = DIM_DEF;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic signed [15:0] o0;
        logic signed [15:0] o1;
        logic signed [15:0] o2;
        logic signed [15:0] o3;
        logic [2:0]         idx;
        logic               degen;
        logic               drop;
        logic               lst;
    } ortho_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    logic signed [31:0] set_store [NVEC][NDIM];
    int                 set_count;
    bit                 set_overflow;
    ortho_result_t      expected_results[$];
    int                 mismatches;
    longint             cycle_count;
    bit                 rx_hold;
    bit                 rx_quiet;
    bit                 tx_quiet;

    gram_schmidt_orthonormalizer_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic signed [63:0] dot_q32(int a, int b);
        logic signed [63:0] acc;
        logic signed [64:0] s;
        acc = 0;
        for (int k = 0; k < NDIM; k++)
        begin
            s = {acc[63], acc} + 65'(signed'(64'(set_store[a][k]) * 64'(set_store[b][k])));
            if (s[64] != s[63])
                acc = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else
                acc = s[63:0];
        end
        return acc;
    endfunction

    function automatic logic [63:0] magnitude(logic signed [63:0] x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    // Projection factor in Q16.16, saturated when the integer part overflows.
    function automatic logic [63:0] ratio_q16(logic [63:0] a, logic [63:0] d);
        logic [63:0] ip;
        logic [63:0] r;
        logic [63:0] fr;
        logic        top;
        ip = a / d;
        r = a % d;
        fr = 0;
        if (ip >= 32768)
            return 64'h7FFFFFFF;
        for (int b = 0; b < 16; b++)
        begin
            top = r[63];
            r = r << 1;
            fr = fr << 1;
            if (top || r >= d)
            begin
                r = r - d;
                fr[0] = 1'b1;
            end
        end
        return (ip << 16) | fr;
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Runs modified Gram-Schmidt on the loaded set and queues one result per vector.
    task automatic predict_orthonormal_set();
        logic signed [63:0] num;
        logic signed [63:0] den;
        logic signed [63:0] nn;
        logic signed [63:0] f;
        logic signed [63:0] p;
        logic signed [63:0] m;
        logic signed [63:0] v;
        logic [63:0]        nrm;
        logic [63:0]        q;
        logic signed [15:0] outs [4];
        ortho_result_t      r;
        for (int i = 1; i < set_count; i++)
            for (int j = 0; j < i; j++)
            begin
                num = dot_q32(j, i);
                den = dot_q32(j, j);
                if (den > 0)
                begin
                    f = 64'(ratio_q16(magnitude(num), 64'(den)));
                    if (num < 0)
                        f = -f;
                    for (int k = 0; k < NDIM; k++)
                    begin
                        p = f * 64'(set_store[j][k]);
                        m = 64'(magnitude(p) >> 16);
                        if (p < 0)
                            m = -m;
                        v = 64'(set_store[i][k]) - m;
                        if (v > 64'sd2147483647)
                            v = 64'sd2147483647;
                        else if (v < -64'sd2147483648)
                            v = -64'sd2147483648;
                        set_store[i][k] = v[31:0];
                    end
                end
            end
        for (int i = 0; i < set_count; i++)
        begin
            nn = dot_q32(i, i);
            nrm = nn > 0 ? root_floor(64'(nn)) : 0;
            for (int k = 0; k < 4; k++)
            begin
                outs[k] = 0;
                if (nrm != 0)
                begin
                    q = (magnitude(64'(set_store[i][k])) << 14) / nrm;
                    if (q > ONE_Q14)
                        q = ONE_Q14;
                    outs[k] = set_store[i][k] < 0 ? -16'(q) : 16'(q);
                end
            end
            r.o0 = outs[0];
            r.o1 = outs[1];
            r.o2 = outs[2];
            r.o3 = outs[3];
            r.idx = 3'(i);
            r.degen = nrm == 0;
            r.drop = set_overflow;
            r.lst = i + 1 == set_count;
            expected_results.push_back(r);
        end
        set_count = 0;
        set_overflow = 0;
    endtask

    task automatic load_vector(logic [63:0] comps, logic lastv);
        if (set_count < NVEC)
        begin
            for (int k = 0; k < NDIM; k++)
                set_store[set_count][k] = k < 4 ? 32'(signed'(comps[16*k +: 16])) * 256 : 0;
            set_count++;
        end
        else
            set_overflow = 1;
        if (lastv)
            predict_orthonormal_set();
    endtask

    // Sends one vector request and predicts once it is accepted.
    // The request stays driven after acceptance until the next call or a drain replaces it.
    task automatic send_vector(logic [63:0] comps, logic lastv);
        while (!tx_quiet && $urandom_range(99) < 12)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= comps;
        s_tlast <= lastv;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        load_vector(comps, lastv);
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(signed'($urandom_range(512) - 256));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] rand_vector();
        return {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
    endfunction

    task automatic test_extremes();
        send_vector({4{16'h7FFF}}, 1'b1);
        send_vector({4{16'h8000}}, 1'b0);
        send_vector({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 1'b0);
        send_vector({16'h0000, 16'h0000, 16'h0000, 16'h0100}, 1'b1);
        send_vector({16'hFFFF, 16'h0001, 16'h0000, 16'hFFFF}, 1'b1);
    endtask

    task automatic test_zero_vectors();
        // A zero first vector contributes nothing to later projections.
        send_vector(64'd0, 1'b0);
        send_vector({16'h0000, 16'h0100, 16'h0200, 16'h0300}, 1'b0);
        send_vector({16'h0000, 16'h0200, 16'h0400, 16'h0600}, 1'b1);
        send_vector(64'd0, 1'b1);
    endtask

    task automatic test_overflow();
        for (int i = 0; i < NVEC + 2; i++)
            send_vector(rand_vector(), i == NVEC + 1);
        for (int i = 0; i < NVEC - 1; i++)
            send_vector(rand_vector(), 1'b0);
        send_vector({16'h0100, 16'h0000, 16'h0000, 16'h0000}, 1'b1);
    endtask

    task automatic test_random_sets(int total);
        int sent;
        int len;
        sent = 0;
        while (sent < total)
        begin
            // Mostly small sets; a few full or overflowing ones.
            len = $urandom_range(9) == 0 ? $urandom_range(NVEC + 2, NVEC) : $urandom_range(4, 1);
            for (int i = 0; i < len; i++)
                send_vector(rand_vector(), i == len - 1);
            sent += len;
            if (sent > total / 3 && sent < total / 3 + 6)
            begin
                tx_quiet = 1;
                rx_quiet = 1;
            end
            else
            begin
                tx_quiet = 0;
                rx_quiet = 0;
            end
        end
    endtask

    // The receiver holds off for a counted stretch while the sender keeps offering.
    task automatic test_backpressure();
        rx_hold = 1;
        fork
            begin
                repeat (1500) @(posedge clk);
                rx_hold = 0;
            end
        join_none
        for (int i = 0; i < 6; i++)
            send_vector(rand_vector(), i % 2 == 1);
        wait_results_drained();
        send_vector(rand_vector(), 1'b0);
        send_vector(rand_vector(), 1'b1);
    endtask

    always @(negedge clk)
    begin
        if (rx_hold)
            m_tready <= 1'b0;
        else
            m_tready <= rx_quiet || $urandom_range(99) >= 12;
    end

    always @(posedge clk)
    begin
        ortho_result_t got;
        ortho_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48],
                   m_tdata[66:64], m_tuser[0], m_tuser[1], m_tlast};
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 64'd0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        set_count = 0;
        set_overflow = 0;
        mismatches = 0;
        cycle_count = 0;
        rx_hold = 0;
        rx_quiet = 0;
        tx_quiet = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_extremes();
        test_zero_vectors();
        test_overflow();
        wait_results_drained();
        test_backpressure();
        test_random_sets(100);
        wait_results_drained();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
